// ===== design/hsvrgbw_pkg.sv =====
package hsvrgbw_pkg;

    localparam int QUEUE_DEPTH_DEF = 4;

    localparam int SECTOR_SIZE = 5461;
    localparam int SECTOR_COUNT = 6;

    localparam logic [14:0] Q_ONE       = 15'd32767;
    localparam logic [14:0] KNEE        = 15'd2621;
    localparam logic [14:0] LOW_SLOPE   = 15'd3628;
    localparam logic [14:0] HIGH_SLOPE  = 15'd28248;
    localparam logic [14:0] HIGH_OFFSET = 15'd4520;

    // hue sectors, named by the primaries they run between
    typedef enum logic [2:0] {
        SEC_RY = 3'd0,
        SEC_YG = 3'd1,
        SEC_GC = 3'd2,
        SEC_CB = 3'd3,
        SEC_BM = 3'd4,
        SEC_MR = 3'd5
    } sector_t;

    typedef struct packed {
        logic [14:0] hue;
        logic [14:0] saturation;
        logic [14:0] brightness;
    } hsv_t;

    typedef struct packed {
        logic [14:0] red_level;
        logic [14:0] green_level;
        logic [14:0] blue_level;
        logic [14:0] white_level;
    } rgbw_t;

    // classified item handed from the front to the back
    typedef struct packed {
        logic        grey;
        sector_t     sector;
        logic [14:0] rem;
        logic [14:0] saturation;
        logic [14:0] brightness;
    } work_t;

    // truncating Q15 multiply
    function automatic logic [14:0] qmul(input logic [14:0] a, input logic [14:0] b);
        logic [29:0] prod;
        prod = 30'(a) * 30'(b);
        return prod[29:15];
    endfunction

endpackage

// ===== design/hsvrgbw_front.sv =====
module hsvrgbw_front (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    output logic                 full,
    input  hsvrgbw_pkg::hsv_t    hsv,
    output logic                 item_valid,
    input  logic                 item_ready,
    output hsvrgbw_pkg::work_t   item
);
    import hsvrgbw_pkg::*;

    logic        front_valid_reg;
    work_t       front_item_reg;
    work_t       front_item_next;
    logic        take;
    logic [2:0]  k;
    logic [14:0] base;
    logic [14:0] diff;

    // count sector boundaries at or below the hue
    always_comb
    begin
        k = 3'd0;
        for (int n = 1; n <= SECTOR_COUNT; n++)
        begin
            if (hsv.hue >= 15'(n * SECTOR_SIZE))
            begin
                k = 3'(n);
            end
        end
        base = 15'(32'(k) * SECTOR_SIZE);
        diff = hsv.hue - base;

        front_item_next.grey       = (hsv.saturation == 15'd0);
        front_item_next.rem        = 15'(diff << 2) + 15'(diff << 1);
        front_item_next.saturation = hsv.saturation;
        front_item_next.brightness = hsv.brightness;
        case (k)
            3'd1:    front_item_next.sector = SEC_YG;
            3'd2:    front_item_next.sector = SEC_GC;
            3'd3:    front_item_next.sector = SEC_CB;
            3'd4:    front_item_next.sector = SEC_BM;
            3'd5:    front_item_next.sector = SEC_MR;
            default: front_item_next.sector = SEC_RY;  // also the top hue codes
        endcase
    end

    assign take       = !front_valid_reg || item_ready;
    assign full       = !take;
    assign item_valid = front_valid_reg;
    assign item       = front_item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_valid_reg <= 1'b0;
        end
        else if (take)
        begin
            front_valid_reg <= push;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take && push)
        begin
            front_item_reg <= front_item_next;
        end
    end

endmodule

// ===== design/hsvrgbw_queue.sv =====
module hsvrgbw_queue #(
    parameter int DEPTH = hsvrgbw_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 wr_valid,
    output logic                 wr_ready,
    input  hsvrgbw_pkg::work_t   wr_data,
    output logic                 rd_valid,
    input  logic                 rd_ready,
    output hsvrgbw_pkg::work_t   rd_data
);
    import hsvrgbw_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    work_t               entry_reg [DEPTH];
    logic [PTR_W-1:0]    wr_ptr_reg;
    logic [PTR_W-1:0]    rd_ptr_reg;
    logic [CNT_W-1:0]    count_reg;
    logic                do_wr;
    logic                do_rd;

    assign wr_ready = (count_reg != CNT_W'(DEPTH));
    assign rd_valid = (count_reg != '0);
    assign rd_data  = entry_reg[rd_ptr_reg];
    assign do_wr    = wr_valid && wr_ready;
    assign do_rd    = rd_valid && rd_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_wr)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_rd)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_wr && !do_rd)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_rd && !do_wr)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            entry_reg[wr_ptr_reg] <= wr_data;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("queue count beyond depth");

    a_count_up: assert property (@(posedge clk) disable iff (!rst_n)
        do_wr && !do_rd |=> count_reg == $past(count_reg) + 1'b1)
        else $error("queue count missed a write");

endmodule

// ===== design/hsvrgbw_back.sv =====
module hsvrgbw_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 space,
    input  logic                 item_valid,
    output logic                 item_ready,
    input  hsvrgbw_pkg::work_t   item,
    output logic                 empty,
    input  logic                 pop,
    output hsvrgbw_pkg::rgbw_t   rgbw
);
    import hsvrgbw_pkg::*;

    logic adv;

    // stage 1: p and the two saturation products
    logic        s1_valid_reg;
    logic        s1_grey_reg;
    sector_t     s1_sector_reg;
    logic [14:0] s1_v_reg, s1_p_reg, s1_kq_reg, s1_kt_reg;

    // stage 2: q, t and the sector mux
    logic                s2_valid_reg;
    logic [2:0][14:0]    s2_chan_reg, s2_chan_next;
    logic [14:0]         q, t;

    // stage 3: linear segment and curve base
    logic                s3_valid_reg;
    logic [2:0][14:0]    s3_x_reg, s3_lo_reg, s3_a_reg;
    logic [2:0][14:0]    s3_lo_next, s3_a_next;
    logic [2:0]          s3_knee_reg, s3_knee_next;
    logic [15:0]         hi_sum [3];

    // stage 4: square
    logic                s4_valid_reg;
    logic [2:0][14:0]    s4_x_reg, s4_lo_reg, s4_a_reg, s4_aa_reg;
    logic [2:0]          s4_knee_reg;

    // stage 5: cube and output select
    logic                s5_valid_reg;
    logic [2:0][14:0]    s5_out_reg, s5_out_next;

    // advance all stages together; hold while a result waits
    assign adv        = !s5_valid_reg || pop;
    assign item_ready = adv;

    always_comb
    begin
        q = qmul(s1_v_reg, Q_ONE - s1_kq_reg);
        t = qmul(s1_v_reg, Q_ONE - s1_kt_reg);
        case (s1_sector_reg)
            SEC_RY:  s2_chan_next = {s1_p_reg, t, s1_v_reg};
            SEC_YG:  s2_chan_next = {s1_p_reg, s1_v_reg, q};
            SEC_GC:  s2_chan_next = {t, s1_v_reg, s1_p_reg};
            SEC_CB:  s2_chan_next = {s1_v_reg, q, s1_p_reg};
            SEC_BM:  s2_chan_next = {s1_v_reg, s1_p_reg, t};
            SEC_MR:  s2_chan_next = {q, s1_p_reg, s1_v_reg};
            default: s2_chan_next = {q, s1_p_reg, s1_v_reg};
        endcase
        if (s1_grey_reg)
        begin
            s2_chan_next = {s1_v_reg, s1_v_reg, s1_v_reg};
        end
    end

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            s3_lo_next[i]   = qmul(s2_chan_reg[i], LOW_SLOPE);
            hi_sum[i]       = {1'b0, qmul(s2_chan_reg[i], HIGH_SLOPE)} + {1'b0, HIGH_OFFSET};
            s3_a_next[i]    = (hi_sum[i] > {1'b0, Q_ONE}) ? Q_ONE : hi_sum[i][14:0];
            s3_knee_next[i] = (s2_chan_reg[i] <= KNEE);
        end
    end

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            if (!space)
            begin
                s5_out_next[i] = s4_x_reg[i];
            end
            else if (s4_knee_reg[i])
            begin
                s5_out_next[i] = s4_lo_reg[i];
            end
            else
            begin
                s5_out_next[i] = qmul(s4_aa_reg[i], s4_a_reg[i]);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
            s5_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_valid_reg <= item_valid;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            s4_valid_reg <= s3_valid_reg;
            s5_valid_reg <= s4_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_grey_reg   <= item.grey;
            s1_sector_reg <= item.sector;
            s1_v_reg      <= item.brightness;
            s1_p_reg      <= qmul(item.brightness, Q_ONE - item.saturation);
            s1_kq_reg     <= qmul(item.rem, item.saturation);
            s1_kt_reg     <= qmul(Q_ONE - item.rem, item.saturation);

            s2_chan_reg   <= s2_chan_next;

            s3_x_reg      <= s2_chan_reg;
            s3_lo_reg     <= s3_lo_next;
            s3_a_reg      <= s3_a_next;
            s3_knee_reg   <= s3_knee_next;

            s4_x_reg      <= s3_x_reg;
            s4_lo_reg     <= s3_lo_reg;
            s4_a_reg      <= s3_a_reg;
            s4_knee_reg   <= s3_knee_reg;
            for (int i = 0; i < 3; i++)
            begin
                s4_aa_reg[i] <= qmul(s3_a_reg[i], s3_a_reg[i]);
            end

            s5_out_reg    <= s5_out_next;
        end
    end

    assign empty            = !s5_valid_reg;
    assign rgbw.red_level   = s5_out_reg[0];
    assign rgbw.green_level = s5_out_reg[1];
    assign rgbw.blue_level  = s5_out_reg[2];
    assign rgbw.white_level = 15'd0;

    a_take_moves: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && adv |=> s1_valid_reg)
        else $error("taken item did not enter stage 1");

    a_grey_equal: assert property (@(posedge clk) disable iff (!rst_n)
        adv && s1_valid_reg && s1_grey_reg |=>
            s2_chan_reg[0] == s2_chan_reg[1] && s2_chan_reg[1] == s2_chan_reg[2])
        else $error("grey item left stage 2 with unequal channels");

    a_hold_result: assert property (@(posedge clk) disable iff (!rst_n)
        !adv |=> $stable(s5_out_reg) && $stable(s4_valid_reg))
        else $error("pipeline moved while stalled");

endmodule

// ===== design/hsv_to_rgbw_perceptual.sv =====
// Channel   Dir  Handshake                Payload
// ------    ---  ----------------------   -------------------------------
// input     in   push / full              hsv  : hue, saturation, brightness
// result    out  empty / pop              rgbw : red, green, blue, white levels
// config    in   cfg_valid / cfg_ready    cfg_data : output_space
//
// One beat per cycle in and out while pop is held high. A beat reaches the
// result ports through the front classify register, which loads on the
// taking edge, then one queue entry and five back stages, a depth set by
// the chain of three dependent Q15 multiplies of the curve after the
// two of the p/q/t terms.
// Reset clears the valid bits, the queue pointers and output_space.
// With pop low the back pipeline fills its five stages and then holds; the
// queue absorbs QUEUE_DEPTH beats and the front register one more before
// full rises.
module hsv_to_rgbw_perceptual #(
    parameter int QUEUE_DEPTH = hsvrgbw_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    output logic                 full,
    input  hsvrgbw_pkg::hsv_t    hsv,
    output logic                 empty,
    input  logic                 pop,
    output hsvrgbw_pkg::rgbw_t   rgbw,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic                 cfg_data
);
    import hsvrgbw_pkg::*;

    // output_space: 0 raw linear, 1 lightness-to-luminance curve
    logic  output_space_reg;

    work_t front_item;
    logic  front_valid;
    logic  front_ready;
    work_t back_item;
    logic  back_valid;
    logic  back_ready;

    // config writes are registered, always ready
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            output_space_reg <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            output_space_reg <= cfg_data;
        end
    end

    // front: take a beat, find sector, remainder and the grey case
    hsvrgbw_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .hsv        (hsv),
        .item_valid (front_valid),
        .item_ready (front_ready),
        .item       (front_item)
    );

    // decouple the two sides so either may stall alone
    hsvrgbw_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (front_valid),
        .wr_ready (front_ready),
        .wr_data  (front_item),
        .rd_valid (back_valid),
        .rd_ready (back_ready),
        .rd_data  (back_item)
    );

    // back: p/q/t terms, channel mux, optional curve, result register
    hsvrgbw_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .space      (output_space_reg),
        .item_valid (back_valid),
        .item_ready (back_ready),
        .item       (back_item),
        .empty      (empty),
        .pop        (pop),
        .rgbw       (rgbw)
    );

endmodule
